>>> src/uba_pkg.sv
// Shared types and constants for the unsigned binary ALU.
package uba_pkg;

  // Fixed widths of the channel fields.
  localparam int KindW    = 4;
  localparam int OperandW = 32;
  localparam int ResultW  = 64;

  // Default operand width; the top level may narrow it.
  localparam int DefWidth = 32;

  typedef enum logic [KindW-1:0] {
    OpAdd = 4'd0,
    OpSub = 4'd1,
    OpMul = 4'd2,
    OpDiv = 4'd3,
    OpAnd = 4'd4,
    OpOr  = 4'd5,
    OpXor = 4'd6,
    OpNot = 4'd7,
    OpGt  = 4'd8
  } op_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // latch the incoming request
    logic init;     // set up the shift-add / divide accumulator
    logic step;     // one multiply or divide iteration
    logic capture;  // write the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic iterative;  // held operation needs the bit-serial unit
  } sts_t;

endpackage

>>> src/uba_if.sv
// Request and response channel interfaces of the unsigned binary ALU.
interface uba_req_if;
  logic                          valid;
  logic                          ready;
  logic [uba_pkg::KindW-1:0]     kind;
  logic [uba_pkg::OperandW-1:0]  operand_a;
  logic [uba_pkg::OperandW-1:0]  operand_b;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

interface uba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [uba_pkg::ResultW-1:0]   result_value;
  logic                          error_flag;

  modport source (output valid, output result_value, output error_flag,
                  input ready);
  modport sink   (input valid, input result_value, input error_flag,
                  output ready);
endinterface

>>> src/uba_dp.sv
// Datapath of the unsigned binary ALU: operand registers, shift-add / restoring
// divide accumulator, result logic and output register.
module uba_dp #(
  parameter int WIDTH = uba_pkg::DefWidth
) (
  input  logic                          clk_i,
  input  logic [uba_pkg::KindW-1:0]     kind_i,
  input  logic [uba_pkg::OperandW-1:0]  operand_a_i,
  input  logic [uba_pkg::OperandW-1:0]  operand_b_i,
  input  uba_pkg::cmd_t                 cmd_i,
  output uba_pkg::sts_t                 sts_o,
  output logic [uba_pkg::ResultW-1:0]   result_value_o,
  output logic                          error_flag_o
);

  localparam int ResW    = uba_pkg::ResultW;
  localparam int SmearN  = $clog2(WIDTH);

  uba_pkg::op_e         kind_q;
  logic [WIDTH-1:0]     a_q, b_q;
  logic [2*WIDTH-1:0]   acc_q, acc_d;
  logic [ResW-1:0]      res_q;
  logic                 flag_q;

  logic [WIDTH-1:0]     acc_hi, acc_lo;
  logic [WIDTH:0]       mul_sum;
  logic [WIDTH:0]       div_trial, div_diff;
  logic                 div_ge;
  logic [WIDTH-1:0]     div_rem;
  logic [WIDTH:0]       add_sum, sub_diff;
  logic [WIDTH-1:0]     sig_mask;
  logic [2*WIDTH-1:0]   res_w;
  logic                 flag_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= uba_pkg::op_e'(kind_i);
      a_q    <= operand_a_i[WIDTH-1:0];
      b_q    <= operand_b_i[WIDTH-1:0];
    end
    acc_q <= acc_d;
    if (cmd_i.capture) begin
      res_q  <= ResW'(res_w);
      flag_q <= flag_w;
    end
  end

  assign acc_hi = acc_q[2*WIDTH-1:WIDTH];
  assign acc_lo = acc_q[WIDTH-1:0];

  // Multiply: add a into the top half when the low bit is set, then shift right.
  assign mul_sum = {1'b0, acc_hi} + {1'b0, (acc_lo[0] ? a_q : {WIDTH{1'b0}})};

  // Divide: top half is the partial remainder, bottom half shifts the
  // dividend out and the quotient in.
  assign div_trial = {acc_hi, acc_lo[WIDTH-1]};
  assign div_diff  = div_trial - {1'b0, b_q};
  assign div_ge    = (div_trial >= {1'b0, b_q});
  assign div_rem   = div_ge ? div_diff[WIDTH-1:0] : div_trial[WIDTH-1:0];

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.init) begin
      acc_d = {{WIDTH{1'b0}}, (kind_q == uba_pkg::OpMul) ? b_q : a_q};
    end else if (cmd_i.step) begin
      if (kind_q == uba_pkg::OpMul) begin
        acc_d = {mul_sum, acc_lo[WIDTH-1:1]};
      end else begin
        acc_d = {div_rem, acc_lo[WIDTH-2:0], div_ge};
      end
    end
  end

  assign sts_o.iterative = (kind_q == uba_pkg::OpMul) || (kind_q == uba_pkg::OpDiv);

  assign add_sum  = {1'b0, a_q} + {1'b0, b_q};
  assign sub_diff = {1'b0, a_q} - {1'b0, b_q};

  // Ones from the top set bit of a downwards; bit 0 always counts.
  always_comb begin
    sig_mask = a_q;
    for (int s = 0; s < SmearN; s++) begin
      sig_mask = sig_mask | (sig_mask >> (1 << s));
    end
    sig_mask[0] = 1'b1;
  end

  always_comb begin
    res_w  = '0;
    flag_w = 1'b0;
    unique case (kind_q)
      uba_pkg::OpAdd: res_w = {{(WIDTH-1){1'b0}}, add_sum};
      uba_pkg::OpSub: begin
        res_w  = {{WIDTH{1'b0}}, sub_diff[WIDTH-1:0]};
        flag_w = sub_diff[WIDTH];
      end
      uba_pkg::OpMul: res_w = acc_q;
      uba_pkg::OpDiv: begin
        if (b_q == '0) begin
          flag_w = 1'b1;
        end else begin
          res_w = {{WIDTH{1'b0}}, acc_lo};
        end
      end
      uba_pkg::OpAnd: res_w = {{WIDTH{1'b0}}, a_q & b_q};
      uba_pkg::OpOr:  res_w = {{WIDTH{1'b0}}, a_q | b_q};
      uba_pkg::OpXor: res_w = {{WIDTH{1'b0}}, a_q ^ b_q};
      uba_pkg::OpNot: res_w = {{WIDTH{1'b0}}, ~a_q & sig_mask};
      uba_pkg::OpGt:  res_w = {{(2*WIDTH-1){1'b0}}, (a_q > b_q)};
      default: begin
        res_w  = '0;
        flag_w = 1'b0;
      end
    endcase
  end

  assign result_value_o = res_q;
  assign error_flag_o   = flag_q;

endmodule

>>> src/uba_ctrl.sv
// Controller of the unsigned binary ALU: request sequencing, iteration count
// and output register occupancy.
module uba_ctrl #(
  parameter int WIDTH = uba_pkg::DefWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output uba_pkg::cmd_t  cmd_o,
  input  uba_pkg::sts_t  sts_i
);

  localparam int CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] LastCnt = CntW'(WIDTH - 1);

  typedef enum logic [3:0] {
    Idle  = 4'b0001,
    Start = 4'b0010,
    Iter  = 4'b0100,
    Done  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_vld_q, out_vld_d;
  logic            req_fire;

  assign req_ready_o = (state_q == Idle);
  assign req_fire    = req_valid_i && req_ready_o;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    out_vld_d = out_vld_q && !rsp_ready_i;
    unique case (state_q)
      Idle: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = Start;
        end
      end
      Start: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.iterative ? Iter : Done;
      end
      Iter: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = Done;
        end
      end
      Done: begin
        // wait for the output register to drain
        if (!out_vld_q || rsp_ready_i) begin
          cmd_o.capture = 1'b1;
          out_vld_d     = 1'b1;
          state_d       = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Idle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign rsp_valid_o = out_vld_q;

  a_fire_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == Start)
    else $error("accepted request did not start");

  a_short_op_skips_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Start) && !sts_i.iterative |=> state_q == Done)
    else $error("single-cycle operation entered iteration");

  a_iter_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Iter) && (cnt_q == LastCnt) |=> state_q == Done)
    else $error("iteration count overran");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Done) && out_vld_q && !rsp_ready_i |=> (state_q == Done) && out_vld_q)
    else $error("result overwrote an untaken response");

endmodule

>>> src/unsigned_binary_alu.sv
// Top level of the unsigned binary ALU.
// Usage: a request on req_i carries kind, operand_a and operand_b; only the
// low WIDTH bits of each operand count. One response on rsp_o follows each
// request with result_value and error_flag. Both channels move a request
// when valid and ready are high at a rising edge of clk_i.
// Sequence: add, sub, logic ops, not and greater pass from Idle through Start
// to Done, where the result is registered, and back to Idle for the next request.
// Multiply and divide run a bit-serial unit, one bit per cycle over WIDTH
// bits, in Iter between Start and Done; the next request is taken only after
// Done. The shared shift-add / restoring divide accumulator sets that pace.
// The response sits in an output register, so the next request is taken
// while an earlier response still waits; a finished result then waits in
// the controller until the receiver drains the register.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the controller to idle; no request or response is in flight afterwards.
module unsigned_binary_alu #(
  parameter int WIDTH = uba_pkg::DefWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uba_req_if.sink   req_i,
  uba_rsp_if.source rsp_o
);

  uba_pkg::cmd_t cmd;
  uba_pkg::sts_t sts;

  uba_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  uba_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .kind_i         (req_i.kind),
    .operand_a_i    (req_i.operand_a),
    .operand_b_i    (req_i.operand_b),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_value_o (rsp_o.result_value),
    .error_flag_o   (rsp_o.error_flag)
  );

endmodule
